// ===== hw/rtl/sha1v_pkg.sv =====
// ----------------------------------------------------------------------------
// sha1v_pkg
// Shared types, codes and constants of the SHA-1 variant engine.
// ----------------------------------------------------------------------------
`default_nettype none

package sha1v_pkg;

  // Operation codes of an input item.
  localparam logic [1:0] OpAbsorb  = 2'd0;
  localparam logic [1:0] OpFinish  = 2'd1;
  localparam logic [1:0] OpRestart = 2'd2;
  localparam logic [1:0] OpUnused  = 2'd3;

  // Variant register codes.
  localparam logic [1:0] VarNormal   = 2'd0;
  localparam logic [1:0] VarLockdown = 2'd1;
  localparam logic [1:0] VarBroken   = 2'd2;
  localparam logic [1:0] VarSpare    = 2'd3;

  // Status codes of a result.
  localparam logic [1:0] StatOk       = 2'd0;
  localparam logic [1:0] StatAfterFin = 2'd1;
  localparam logic [1:0] StatTooLong  = 2'd2;

  localparam int unsigned NumWords  = 5;
  localparam int unsigned NumRounds = 80;
  localparam int unsigned LastWord  = NumWords - 1;
  localparam int unsigned LastRound = NumRounds - 1;

  localparam logic [31:0] InitH [5] = '{
    32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
  };
  localparam logic [31:0] RoundK [4] = '{
    32'h5A827999, 32'h6ED9EBA1, 32'h8F1BBCDC, 32'hCA62C1D6
  };
  localparam logic [7:0] PadMarker = 8'h80;
  localparam logic [5:0] LastLenPos = 6'd55;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ROUND,
    S_ADD,
    S_PAD2,
    S_EMIT
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       absorb;
    logic       restart;
    logic       pad1;
    logic       pad2;
    logic       round;
    logic       add;
    logic       load_out;
    logic [6:0] rnd;
    logic [2:0] idx;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic full;
    logic two_blk;
    logic err;
    logic finished;
  } status_t;

endpackage

`default_nettype wire

// ===== hw/rtl/sha1v_in_if.sv =====
// ----------------------------------------------------------------------------
// sha1v_in_if
// Input channel: operation and message byte with valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface sha1v_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] operation;
  logic [7:0] data_byte;

  modport source (output valid, output operation, output data_byte, input ready);
  modport sink (input valid, input operation, input data_byte, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/sha1v_out_if.sv =====
// ----------------------------------------------------------------------------
// sha1v_out_if
// Result channel: one digest word per transfer with valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface sha1v_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  word_index;
  logic [31:0] digest_word;
  logic        is_last;
  logic [31:0] fold;
  logic [1:0]  status;

  modport source (output valid, output word_index, output digest_word,
                  output is_last, output fold, output status, input ready);
  modport sink (input valid, input word_index, input digest_word,
                input is_last, input fold, input status, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/sha1v_ctrl.sv =====
// ----------------------------------------------------------------------------
// sha1v_ctrl
// Sequencer: decodes items, runs the 80 rounds and the digest transfers.
// ----------------------------------------------------------------------------
`default_nettype none

module sha1v_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  input  wire logic [1:0]       in_op_i,
  output logic                  in_ready_o,
  input  wire logic             out_ready_i,
  output logic                  out_valid_o,
  input  wire sha1v_pkg::status_t st_i,
  output sha1v_pkg::cmd_t       cmd_o
);
  import sha1v_pkg::*;

  state_e     state_q, state_d;
  logic [6:0] rnd_q, rnd_d;
  logic [2:0] idx_q, idx_d;
  logic       two_q, two_d;
  logic       fin_q, fin_d;
  logic       ov_q, ov_d;
  logic       take;

  // State registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      rnd_q   <= '0;
      idx_q   <= '0;
      two_q   <= 1'b0;
      fin_q   <= 1'b0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      rnd_q   <= rnd_d;
      idx_q   <= idx_d;
      two_q   <= two_d;
      fin_q   <= fin_d;
      ov_q    <= ov_d;
    end
  end

  // Next state and commands.
  always_comb begin
    state_d = state_q;
    rnd_d   = rnd_q;
    idx_d   = idx_q;
    two_d   = two_q;
    fin_d   = fin_q;
    cmd_o   = '0;
    cmd_o.rnd = rnd_q;
    cmd_o.idx = idx_q;
    in_ready_o = 1'b0;
    take = !ov_q || out_ready_i;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          case (in_op_i)
            OpAbsorb: begin
              cmd_o.absorb = 1'b1;
              if (st_i.full) begin
                rnd_d   = '0;
                state_d = S_ROUND;
              end
            end
            OpRestart: cmd_o.restart = 1'b1;
            OpFinish: begin
              idx_d = '0;
              if (st_i.err || st_i.finished) begin
                state_d = S_EMIT;
              end else begin
                cmd_o.pad1 = 1'b1;
                two_d   = st_i.two_blk;
                fin_d   = 1'b1;
                rnd_d   = '0;
                state_d = S_ROUND;
              end
            end
            default: ;
          endcase
        end
      end
      S_ROUND: begin
        cmd_o.round = 1'b1;
        rnd_d = rnd_q + 7'd1;
        if (rnd_q == 7'(LastRound)) state_d = S_ADD;
      end
      S_ADD: begin
        cmd_o.add = 1'b1;
        if (two_q) begin
          two_d   = 1'b0;
          state_d = S_PAD2;
        end else if (fin_q) begin
          fin_d   = 1'b0;
          state_d = S_EMIT;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_PAD2: begin
        cmd_o.pad2 = 1'b1;
        rnd_d   = '0;
        state_d = S_ROUND;
      end
      S_EMIT: begin
        if (take) begin
          cmd_o.load_out = 1'b1;
          idx_d = idx_q + 3'd1;
          if (st_i.err || idx_q == 3'(LastWord)) state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Result valid: set on a load, cleared when the transfer completes.
  always_comb begin
    if (cmd_o.load_out) ov_d = 1'b1;
    else if (out_ready_i) ov_d = 1'b0;
    else ov_d = ov_q;
  end

  assign out_valid_o = ov_q;

endmodule

`default_nettype wire

// ===== hw/rtl/sha1v_dp.sv =====
// ----------------------------------------------------------------------------
// sha1v_dp
// Datapath: block buffer as message schedule, round logic, chain and result.
// ----------------------------------------------------------------------------
`default_nettype none

module sha1v_dp (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_we_i,
  input  wire logic [1:0]       cfg_wdata_i,
  input  wire logic [7:0]       data_byte_i,
  input  wire sha1v_pkg::cmd_t  cmd_i,
  output sha1v_pkg::status_t    st_o,
  output logic [2:0]            word_index_o,
  output logic [31:0]           digest_word_o,
  output logic                  is_last_o,
  output logic [31:0]           fold_o,
  output logic [1:0]            status_o
);
  import sha1v_pkg::*;

  logic [1:0]  var_q;
  logic [31:0] chain_q [5];
  logic [31:0] chain_d [5];
  logic [31:0] blk_q [16];
  logic [31:0] blk_d [16];
  logic [5:0]  pos_q, pos_d;
  logic [63:0] bc_q, bc_d, bc_inc;
  logic        fin_q, fin_d;
  logic [1:0]  err_q, err_d;
  logic [31:0] a_q, b_q, c_q, d_q, e_q;
  logic [31:0] a_d, b_d, c_d, d_d, e_d;
  logic [2:0]  oidx_q, oidx_d;
  logic [31:0] oword_q, oword_d, ofold_q, ofold_d;
  logic        olast_q, olast_d;
  logic [1:0]  ostat_q, ostat_d;
  logic        little, broken, ok_abs, two_blk, load_abc;
  logic [31:0] dig [5];
  logic [31:0] fold_all, x, wnew, f, k, tmp;
  logic [31:0] len_w14, len_w15;
  logic [4:0]  lane_off;
  logic [5:0]  pad_pos;

  assign little   = (var_q == VarLockdown) || (var_q == VarBroken);
  assign broken   = (var_q == VarBroken);
  assign bc_inc   = bc_q + 64'd8;
  assign ok_abs   = (err_q == StatOk) && !fin_q;
  assign two_blk  = !broken && (pos_q > LastLenPos);
  assign lane_off = {~pos_q[1:0], 3'b000};
  assign len_w14  = (var_q == VarLockdown) ? bc_q[31:0] : bc_q[63:32];
  assign len_w15  = (var_q == VarLockdown) ? bc_q[63:32] : bc_q[31:0];

  assign st_o.full     = ok_abs && (bc_inc != '0) && (pos_q == 6'd63);
  assign st_o.two_blk  = two_blk;
  assign st_o.err      = (err_q != StatOk);
  assign st_o.finished = fin_q;

  // Digest words in output byte order and their fold.
  always_comb begin
    fold_all = '0;
    for (int i = 0; i < 5; i++) begin
      dig[3'(i)] = (var_q == VarNormal) ?
                   {chain_q[3'(i)][7:0], chain_q[3'(i)][15:8],
                    chain_q[3'(i)][23:16], chain_q[3'(i)][31:24]} :
                   chain_q[3'(i)];
      fold_all ^= dig[3'(i)];
    end
  end

  // Message expansion and round function.
  always_comb begin
    x    = blk_q[13] ^ blk_q[8] ^ blk_q[2] ^ blk_q[0];
    wnew = broken ? (32'd1 << x[4:0]) : {x[30:0], x[31]};
    if (cmd_i.rnd < 7'd20) begin
      f = (b_q & c_q) | (~b_q & d_q);
      k = RoundK[0];
    end else if (cmd_i.rnd < 7'd40) begin
      f = b_q ^ c_q ^ d_q;
      k = RoundK[1];
    end else if (cmd_i.rnd < 7'd60) begin
      f = (b_q & c_q) | (b_q & d_q) | (c_q & d_q);
      k = RoundK[2];
    end else begin
      f = b_q ^ c_q ^ d_q;
      k = RoundK[3];
    end
    tmp = {a_q[26:0], a_q[31:27]} + f + e_q + blk_q[0] + k;
  end

  // Buffer, schedule and working variables. Bytes are kept in big-endian
  // lane order; the variant in force when a compression starts decides
  // how the words are loaded.
  always_comb begin
    blk_d    = blk_q;
    load_abc = 1'b0;
    pad_pos  = '0;
    a_d = a_q; b_d = b_q; c_d = c_q; d_d = d_q; e_d = e_q;
    if (cmd_i.absorb && ok_abs && (bc_inc != '0)) begin
      blk_d[pos_q[5:2]][lane_off +: 8] = data_byte_i;
      load_abc = (pos_q == 6'd63);
    end
    if (cmd_i.pad1) begin
      // Marker at the current position (zero in the broken variant), zeros after it.
      for (int b = 0; b < 64; b++) begin
        pad_pos = 6'(b);
        if (pad_pos == pos_q) begin
          blk_d[pad_pos[5:2]][{~pad_pos[1:0], 3'b000} +: 8] =
            broken ? 8'h00 : PadMarker;
        end else if (pad_pos > pos_q) begin
          blk_d[pad_pos[5:2]][{~pad_pos[1:0], 3'b000} +: 8] = 8'h00;
        end
      end
      load_abc = 1'b1;
    end
    // The little-endian variants load each message word byte-swapped.
    if (load_abc && little) begin
      for (int j = 0; j < 16; j++) begin
        blk_d[4'(j)] = {blk_d[4'(j)][7:0], blk_d[4'(j)][15:8],
                        blk_d[4'(j)][23:16], blk_d[4'(j)][31:24]};
      end
    end
    // Length words are placed as final word values.
    if (cmd_i.pad1 && !broken && !two_blk) begin
      blk_d[14] = len_w14;
      blk_d[15] = len_w15;
    end
    if (cmd_i.pad2) begin
      for (int j = 0; j < 14; j++) blk_d[4'(j)] = '0;
      blk_d[14] = len_w14;
      blk_d[15] = len_w15;
      load_abc = 1'b1;
    end
    if (cmd_i.round) begin
      for (int j = 0; j < 15; j++) blk_d[4'(j)] = blk_q[4'(j + 1)];
      blk_d[15] = wnew;
      e_d = d_q;
      d_d = c_q;
      c_d = {b_q[1:0], b_q[31:2]};
      b_d = a_q;
      a_d = tmp;
    end
    if (load_abc) begin
      a_d = chain_q[0]; b_d = chain_q[1]; c_d = chain_q[2];
      d_d = chain_q[3]; e_d = chain_q[4];
    end
  end

  // Message state: chain, position, bit count and error.
  always_comb begin
    chain_d = chain_q;
    pos_d   = pos_q;
    bc_d    = bc_q;
    fin_d   = fin_q;
    err_d   = err_q;
    if (cmd_i.absorb && (err_q == StatOk)) begin
      if (fin_q) begin
        err_d = StatAfterFin;
      end else begin
        bc_d = bc_inc;
        if (bc_inc == '0) err_d = StatTooLong;
        else pos_d = pos_q + 6'd1;
      end
    end
    if (cmd_i.pad1) begin
      fin_d = 1'b1;
      if (!two_blk) bc_d = '0;
    end
    if (cmd_i.pad2) bc_d = '0;
    if (cmd_i.add) begin
      chain_d[0] = chain_q[0] + a_q;
      chain_d[1] = chain_q[1] + b_q;
      chain_d[2] = chain_q[2] + c_q;
      chain_d[3] = chain_q[3] + d_q;
      chain_d[4] = chain_q[4] + e_q;
      pos_d = '0;
    end
    if (cmd_i.restart) begin
      chain_d = InitH;
      pos_d   = '0;
      bc_d    = '0;
      fin_d   = 1'b0;
      err_d   = StatOk;
    end
  end

  // Result payload for the next transfer.
  always_comb begin
    oidx_d = oidx_q; oword_d = oword_q; olast_d = olast_q;
    ofold_d = ofold_q; ostat_d = ostat_q;
    if (cmd_i.load_out) begin
      if (err_q != StatOk) begin
        oidx_d = '0; oword_d = '0; olast_d = 1'b1; ofold_d = '0; ostat_d = err_q;
      end else begin
        oidx_d  = cmd_i.idx;
        olast_d = (cmd_i.idx == 3'(LastWord));
        ofold_d = olast_d ? fold_all : '0;
        ostat_d = StatOk;
        case (cmd_i.idx)
          3'd0: oword_d = dig[0];
          3'd1: oword_d = dig[1];
          3'd2: oword_d = dig[2];
          3'd3: oword_d = dig[3];
          default: oword_d = dig[4];
        endcase
      end
    end
  end

  // Control and message state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      var_q   <= VarNormal;
      chain_q <= InitH;
      pos_q   <= '0;
      bc_q    <= '0;
      fin_q   <= 1'b0;
      err_q   <= StatOk;
    end else begin
      if (cfg_we_i) var_q <= cfg_wdata_i;
      chain_q <= chain_d;
      pos_q   <= pos_d;
      bc_q    <= bc_d;
      fin_q   <= fin_d;
      err_q   <= err_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    blk_q   <= blk_d;
    a_q <= a_d; b_q <= b_d; c_q <= c_d; d_q <= d_d; e_q <= e_d;
    oidx_q  <= oidx_d;
    oword_q <= oword_d;
    olast_q <= olast_d;
    ofold_q <= ofold_d;
    ostat_q <= ostat_d;
  end

  assign word_index_o  = oidx_q;
  assign digest_word_o = oword_q;
  assign is_last_o     = olast_q;
  assign fold_o        = ofold_q;
  assign status_o      = ostat_q;

endmodule

`default_nettype wire

// ===== hw/rtl/sha1_hash_with_variants_top.sv =====
// ----------------------------------------------------------------------------
// sha1_hash_with_variants_top
// Byte-stream SHA-1 engine with standard, lockdown and broken variants.
// ----------------------------------------------------------------------------
// An absorb or restart item is taken while idle. The byte that completes a
// 64-byte block starts the compression, which runs one round per cycle:
// 80 rounds, then the chain update, before the next item is taken. A finish
// pads and compresses one block, or two when the marker leaves no room for
// the length, then issues five transfers, one per digest word, at one per
// cycle while the sink is ready. A finish of a closed message skips the
// compression; a finish with a sticky error gives a single transfer. The
// block-buffer register file is also the message schedule, so the round
// loop sets the rate.
// ----------------------------------------------------------------------------
`default_nettype none

module sha1_hash_with_variants_top (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_we_i,
  input  wire logic [1:0] cfg_wdata_i,
  sha1v_in_if.sink        req_i,
  sha1v_out_if.source     rsp_o
);
  import sha1v_pkg::*;

  cmd_t    cmd;
  status_t st;

  // Sequencer.
  sha1v_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_op_i     (req_i.operation),
    .in_ready_o  (req_i.ready),
    .out_ready_i (rsp_o.ready),
    .out_valid_o (rsp_o.valid),
    .st_i        (st),
    .cmd_o       (cmd)
  );

  // Datapath.
  sha1v_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .data_byte_i   (req_i.data_byte),
    .cmd_i         (cmd),
    .st_o          (st),
    .word_index_o  (rsp_o.word_index),
    .digest_word_o (rsp_o.digest_word),
    .is_last_o     (rsp_o.is_last),
    .fold_o        (rsp_o.fold),
    .status_o      (rsp_o.status)
  );

endmodule

`default_nettype wire

// ===== bench/sha1_hash_with_variants_top_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sha1_hash_with_variants_top_tb
// Self-checking bench for the SHA-1 variant engine.
// ----------------------------------------------------------------------------
// Byte messages of random length and content are hashed under every variant
// setting, with restarts, repeated finishes, input after a finish and the
// unused operation mixed in. A scoreboard computes the digest words of each
// finish and compares every result transfer, field by field, in order.
// Both channels stall in random bursts, except in the last phase.
// ----------------------------------------------------------------------------

module sha1_hash_with_variants_top_tb;
  import sha1v_pkg::*;

  typedef struct {
    logic [2:0]  word_index;
    logic [31:0] digest_word;
    logic        is_last;
    logic [31:0] fold;
    logic [1:0]  status;
  } digest_rsp_t;

  // Digest predictor and store of the digest words still to come.
  class digest_scoreboard;
    logic [1:0]  variant;
    logic [31:0] chain [5];
    logic [7:0]  blk [64];
    int unsigned pos;
    logic [63:0] bit_cnt;
    bit          closed;
    logic [1:0]  err;
    digest_rsp_t pending_q [$];
    int unsigned mismatches;

    function new();
      variant = VarNormal;
      mismatches = 0;
      clear();
    endfunction

    function void clear();
      foreach (chain[i]) chain[i] = InitH[i];
      foreach (blk[i]) blk[i] = 8'h00;
      pos = 0;
      bit_cnt = '0;
      closed = 1'b0;
      err = StatOk;
    endfunction

    function logic [31:0] rotl(logic [31:0] x, int unsigned n);
      n = n % 32;
      if (n == 0) return x;
      return (x << n) | (x >> (32 - n));
    endfunction

    function void compress();
      logic [31:0] w [80];
      logic [31:0] a, b, c, d, e, f, tmp, x;
      bit little;
      little = (variant == VarLockdown) || (variant == VarBroken);
      for (int t = 0; t < 16; t++) begin
        if (little)
          w[t] = {blk[4*t+3], blk[4*t+2], blk[4*t+1], blk[4*t]};
        else
          w[t] = {blk[4*t], blk[4*t+1], blk[4*t+2], blk[4*t+3]};
      end
      for (int t = 16; t < 80; t++) begin
        x = w[t-3] ^ w[t-8] ^ w[t-14] ^ w[t-16];
        w[t] = (variant == VarBroken) ? (32'd1 << x[4:0]) : rotl(x, 1);
      end
      a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3]; e = chain[4];
      for (int t = 0; t < 80; t++) begin
        if (t < 20) f = (b & c) | (~b & d);
        else if (t < 40) f = b ^ c ^ d;
        else if (t < 60) f = (b & c) | (b & d) | (c & d);
        else f = b ^ c ^ d;
        tmp = rotl(a, 5) + f + e + w[t] + RoundK[t / 20];
        e = d; d = c; c = rotl(b, 30); b = a; a = tmp;
      end
      chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d; chain[4] += e;
      pos = 0;
    endfunction

    function void put_len(logic [31:0] v, int unsigned at, bit little);
      for (int k = 0; k < 4; k++)
        blk[at + k] = little ? v[8*k +: 8] : v[8*(3-k) +: 8];
    endfunction

    function void pad_message();
      pos = pos % 64;
      if (variant != VarBroken) begin
        blk[pos] = 8'h80;
        pos++;
        if (pos > 56) begin
          while (pos < 64) blk[pos++] = 8'h00;
          compress();
        end
        while (pos < 56) blk[pos++] = 8'h00;
        if (variant == VarLockdown) begin
          put_len(bit_cnt[31:0], 56, 1'b1);
          put_len(bit_cnt[63:32], 60, 1'b1);
        end else begin
          put_len(bit_cnt[63:32], 56, 1'b0);
          put_len(bit_cnt[31:0], 60, 1'b0);
        end
      end else begin
        while (pos < 64) blk[pos++] = 8'h00;
      end
      compress();
    endfunction

    // Note an accepted input transfer and queue the digest words it causes.
    function void note_input(logic [1:0] op, logic [7:0] data);
      digest_rsp_t r;
      logic [31:0] words [5];
      logic [31:0] acc;
      if (op == OpAbsorb) begin
        if (err != StatOk) return;
        if (closed) begin
          err = StatAfterFin;
          return;
        end
        bit_cnt += 64'd8;
        if (bit_cnt == '0) begin
          err = StatTooLong;
          return;
        end
        blk[pos % 64] = data;
        pos = (pos % 64) + 1;
        if (pos == 64) compress();
      end else if (op == OpRestart) begin
        clear();
      end else if (op == OpFinish) begin
        if (err != StatOk) begin
          r = '{3'd0, 32'd0, 1'b1, 32'd0, err};
          pending_q.push_back(r);
          return;
        end
        if (!closed) begin
          pad_message();
          bit_cnt = '0;
          closed = 1'b1;
        end
        acc = '0;
        for (int i = 0; i < 5; i++) begin
          words[i] = (variant == VarNormal) ? {<<8{chain[i]}} : chain[i];
          acc ^= words[i];
        end
        for (int i = 0; i < 5; i++) begin
          r.word_index = 3'(i);
          r.digest_word = words[i];
          r.is_last = (i == LastWord);
          r.fold = (i == LastWord) ? acc : 32'd0;
          r.status = StatOk;
          pending_q.push_back(r);
        end
      end
    endfunction

    // Compare one result transfer with the oldest expected digest word.
    function void check_result(digest_rsp_t got);
      digest_rsp_t exp_r;
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected result idx=%0d word=%h", $realtime,
                   got.word_index, got.digest_word);
        return;
      end
      exp_r = pending_q.pop_front();
      if (got.word_index !== exp_r.word_index ||
          got.digest_word !== exp_r.digest_word ||
          got.is_last !== exp_r.is_last || got.fold !== exp_r.fold ||
          got.status !== exp_r.status) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"%0t: mismatch exp idx=%0d word=%h last=%b fold=%h st=%0d,",
                    " got idx=%0d word=%h last=%b fold=%h st=%0d"},
                   $realtime, exp_r.word_index, exp_r.digest_word, exp_r.is_last,
                   exp_r.fold, exp_r.status, got.word_index, got.digest_word,
                   got.is_last, got.fold, got.status);
      end
    endfunction
  endclass

  localparam int unsigned CycleLimit = 3000000;
  localparam int unsigned SettleCycles = 200;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [1:0] cfg_wdata;
  bit idle_on;
  int unsigned stall_left;
  int unsigned cycles;
  int unsigned items_sent;
  digest_scoreboard sb;

  sha1v_in_if req_if ();
  sha1v_out_if rsp_if ();

  sha1_hash_with_variants_top uut (
    .clk_i(clk),
    .rst_ni(rst_n),
    .cfg_we_i(cfg_we),
    .cfg_wdata_i(cfg_wdata),
    .req_i(req_if),
    .rsp_o(rsp_if)
  );

  always #5 clk = ~clk;

  // Cycle count and timeout.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Result side backpressure in random bursts.
  always @(posedge clk) begin
    if (stall_left > 0) begin
      rsp_if.ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      rsp_if.ready <= 1'b0;
      stall_left <= $urandom_range(0, 13);
    end else begin
      rsp_if.ready <= 1'b1;
    end
  end

  // Check every result transfer.
  always @(posedge clk) begin
    digest_rsp_t got;
    if (rst_n && rsp_if.valid && rsp_if.ready) begin
      got = '{rsp_if.word_index, rsp_if.digest_word, rsp_if.is_last, rsp_if.fold,
              rsp_if.status};
      sb.check_result(got);
    end
  end

  // Drive one input item and wait for its transfer.
  task automatic send_item(logic [1:0] op, logic [7:0] data);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    req_if.valid <= 1'b1;
    req_if.operation <= op;
    req_if.data_byte <= data;
    do @(posedge clk); while (!req_if.ready);
    sb.note_input(op, data);
    items_sent++;
  endtask

  // Let the engine go quiet: all digests out and any block compression done.
  task automatic drain();
    req_if.valid <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_variant(logic [1:0] v);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.variant = v;
  endtask

  // One message: restart, random bytes, finish, sometimes extra finishes.
  task automatic send_message(int unsigned len);
    send_item(OpRestart, 8'($urandom));
    for (int unsigned i = 0; i < len; i++) send_item(OpAbsorb, 8'($urandom));
    send_item(OpFinish, 8'($urandom));
    if ($urandom_range(0, 5) == 0) send_item(OpFinish, 8'h00);
    if ($urandom_range(0, 9) == 0) begin
      send_item(OpAbsorb, 8'($urandom));
      send_item(OpFinish, 8'h00);
    end
    if ($urandom_range(0, 9) == 0) send_item(OpUnused, 8'($urandom));
  endtask

  function automatic int unsigned pick_len();
    int unsigned sel;
    sel = $urandom_range(0, 9);
    if (sel < 6) return $urandom_range(0, 40);
    if (sel < 9) return $urandom_range(50, 70);
    return $urandom_range(110, 135);
  endfunction

  initial begin
    logic [1:0] plan [8];
    plan = '{VarNormal, VarLockdown, VarBroken, VarSpare, VarBroken, VarNormal,
             VarLockdown, VarNormal};
    sb = new();
    clk = 1'b0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = VarNormal;
    req_if.valid = 1'b0;
    req_if.operation = OpAbsorb;
    req_if.data_byte = 8'h00;
    rsp_if.ready = 1'b0;
    idle_on = 1'b1;
    stall_left = 0;
    cycles = 0;
    items_sent = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: byte extremes, repeated finish, input after finish,
    // finish with an error set, the unused operation and an empty message.
    send_item(OpFinish, 8'h00);
    send_item(OpRestart, 8'h00);
    send_item(OpAbsorb, 8'h00);
    send_item(OpAbsorb, 8'hFF);
    send_item(OpAbsorb, 8'h55);
    send_item(OpAbsorb, 8'hAA);
    send_item(OpFinish, 8'hFF);
    send_item(OpFinish, 8'h00);
    send_item(OpAbsorb, 8'h12);
    send_item(OpFinish, 8'h00);
    send_item(OpAbsorb, 8'h34);
    send_item(OpUnused, 8'hFF);
    send_item(OpFinish, 8'h00);
    send_item(OpRestart, 8'hFF);
    send_item(OpUnused, 8'h00);
    send_item(OpAbsorb, 8'h61);
    send_item(OpFinish, 8'h00);

    // Random messages under each variant; each phase opens with a length that
    // just fits the length field, leaves no room for it or fills a block exactly.
    foreach (plan[p]) begin
      write_variant(plan[p]);
      if (p == 7) idle_on = 1'b0;
      case (p % 3)
        0: send_message(55);
        1: send_message(56);
        default: send_message(64);
      endcase
      while (items_sent < 65 * (p + 1)) send_message(pick_len());
    end

    drain();
    if (sb.mismatches == 0 && sb.pending_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/sha1v_pkg.sv
hw/rtl/sha1v_in_if.sv
hw/rtl/sha1v_out_if.sv
hw/rtl/sha1v_ctrl.sv
hw/rtl/sha1v_dp.sv
hw/rtl/sha1_hash_with_variants_top.sv
bench/sha1_hash_with_variants_top_tb.sv
